@@ hw/rtl/sht_pkg.sv @@
// Package for the hash table engine: sizes, tag codes, op and status codes.
// No dependencies.
`default_nettype none
package sht_pkg;
    localparam int BUCKETS     = 64;
    localparam int SLOTS       = 16;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int BKT_W       = $clog2(BUCKETS);
    localparam int SLOT_W      = 4;
    localparam int ADDR_W      = BKT_W + SLOT_W;
    localparam int PROBE_W     = BKT_W + 1;

    localparam logic [7:0] TAG_EMPTY = 8'h00;
    localparam logic [7:0] TAG_TOMB  = 8'h80;
    localparam logic [7:0] TAG_ZFIX  = 8'hFF;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
endpackage
`default_nettype wire

@@ hw/rtl/sht_ram.sv @@
// Generic simple dual-port RAM with registered read, one write per cycle.
// No dependencies.
`default_nettype none
module sht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/swiss_hash_table_engine.sv @@
// Hash table engine top: probe sequencer, tag clear sweep, slot compare unit.
// Uses sht_pkg and sht_ram.
//
// Usage: one request item per in_valid/in_ready handshake (op, hash, key,
// value); one result item (status, existed, value_out) per request on
// out_valid/out_ready. One request is worked at a time; in_ready is low while
// busy or while a result waits to be taken.
// Each probed bucket is scanned slot by slot through one shared compare unit:
// its 16 slots are read in turn, each tag and key is compared when its read
// data returns, and the bucket is then closed; a hit ends the probe. After
// the scan comes a decide/write-back state, and a find or remove hit adds
// the value read states S_VREAD and S_VWAIT. out_valid is set as the last
// of these states ends. Probing ends after an all-empty bucket or after all
// 64 buckets.
// After reset a sweep clears all 1024 tag slots, one slot a
// cycle, during which no request is accepted. Keys and values are not reset.
// A stalled receiver holds the result in the output register; no new
// request is taken until it is delivered.
`default_nettype none
module swiss_hash_table_engine (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      op,
    input  wire logic [63:0]                     hash,
    input  wire logic [sht_pkg::KEY_BITS-1:0]    key,
    input  wire logic [sht_pkg::VALUE_BITS-1:0]  value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           status,
    output logic                                 existed,
    output logic [sht_pkg::VALUE_BITS-1:0]       value_out
);
    import sht_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_VREAD, S_VWAIT,
                              S_OUT} state_t;

    state_t             state_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic [1:0]         op_reg;
    logic [BKT_W-1:0]   bkt_reg;
    logic [PROBE_W-1:0] p_reg;
    logic [7:0]         tag_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [SLOT_W:0]    slot_reg;     // slot being addressed, 16 = done issuing
    logic               rd_vld_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic               found_reg, have_free_reg, nonempty_reg;
    logic [ADDR_W-1:0]  match_reg, free_reg;

    // memory ports
    logic              t_we, kv_we, v_we;
    logic [ADDR_W-1:0] t_wa, t_ra, kv_wa, kv_ra;
    logic [7:0]        t_wd, t_rd;
    logic [KEY_BITS-1:0]   k_rd;
    logic [VALUE_BITS-1:0] v_rd, v_wd;

    sht_ram #(.WIDTH(8), .DEPTH(BUCKETS*SLOTS)) u_tags (
        .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
    sht_ram #(.WIDTH(KEY_BITS), .DEPTH(BUCKETS*SLOTS)) u_keys (
        .clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(key_reg), .raddr(kv_ra),
        .rdata(k_rd));
    sht_ram #(.WIDTH(VALUE_BITS), .DEPTH(BUCKETS*SLOTS)) u_vals (
        .clk(clk), .we(v_we), .waddr(kv_wa), .wdata(v_wd), .raddr(kv_ra),
        .rdata(v_rd));

    logic [ADDR_W-1:0] rd_addr;
    logic              hit, free_hit;
    logic [ADDR_W-1:0] rd_full;
    logic [7:0]        in_tag;

    assign in_tag   = (hash[63:57] == 7'd0) ? TAG_ZFIX : {1'b0, hash[63:57]};
    assign rd_addr  = {bkt_reg, slot_reg[SLOT_W-1:0]};
    assign rd_full  = {bkt_reg, rd_slot_reg};
    assign hit      = rd_vld_reg && (t_rd == tag_reg) && (k_rd == key_reg);
    assign free_hit = rd_vld_reg && ((t_rd == TAG_EMPTY) || (t_rd == TAG_TOMB));
    assign in_ready = (state_reg == S_IDLE);

    // write side, all in S_DECIDE or clearing
    always_comb
    begin
        t_we  = 1'b0;
        t_wa  = clr_reg;
        t_wd  = TAG_EMPTY;
        kv_we = 1'b0;
        v_we  = 1'b0;
        kv_wa = free_reg;
        v_wd  = val_reg;
        t_ra  = (state_reg == S_VREAD) ? match_reg : rd_addr;
        kv_ra = t_ra;
        case (state_reg)
            S_CLEAR:
            begin
                t_we = 1'b1;
            end
            S_DECIDE:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (found_reg)
                    begin
                        v_we  = 1'b1;
                        kv_wa = match_reg;
                    end
                    else if (have_free_reg)
                    begin
                        t_we  = 1'b1;
                        t_wa  = free_reg;
                        t_wd  = tag_reg;
                        kv_we = 1'b1;
                        v_we  = 1'b1;
                    end
                end
                else if ((op_reg == OP_REMOVE) && found_reg)
                begin
                    t_we = 1'b1;
                    t_wa = match_reg;
                    t_wd = TAG_TOMB;
                end
            end
            default:
            begin
            end
        endcase
    end

    // next probe bucket: home + p(p+1)/2, kept incrementally as bkt += p+1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            out_valid  <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(BUCKETS*SLOTS-1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg        <= op;
                        tag_reg       <= in_tag;
                        key_reg       <= key;
                        val_reg       <= value;
                        bkt_reg       <= hash[BKT_W-1:0];
                        p_reg         <= '0;
                        slot_reg      <= '0;
                        rd_vld_reg    <= 1'b0;
                        found_reg     <= 1'b0;
                        have_free_reg <= 1'b0;
                        nonempty_reg  <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    rd_vld_reg  <= !slot_reg[SLOT_W] && !hit;
                    rd_slot_reg <= slot_reg[SLOT_W-1:0];
                    if (!slot_reg[SLOT_W])
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                    if (free_hit && !have_free_reg)
                    begin
                        have_free_reg <= 1'b1;
                        free_reg      <= rd_full;
                    end
                    if (rd_vld_reg && (t_rd != TAG_EMPTY))
                    begin
                        nonempty_reg <= 1'b1;
                    end
                    if (hit)
                    begin
                        found_reg  <= 1'b1;
                        match_reg  <= rd_full;
                        rd_vld_reg <= 1'b0;
                        state_reg  <= S_DECIDE;
                    end
                    else if (slot_reg[SLOT_W] && !rd_vld_reg)
                    begin
                        // bucket done; current bucket's flag includes last slot
                        if (!nonempty_reg || (p_reg == PROBE_W'(BUCKETS-1)))
                        begin
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            p_reg        <= p_reg + 1'b1;
                            bkt_reg      <= bkt_reg + BKT_W'(p_reg + 1'b1);
                            slot_reg     <= '0;
                            nonempty_reg <= 1'b0;
                        end
                    end
                end
                S_DECIDE:
                begin
                    existed   <= found_reg;
                    value_out <= '0;
                    if (op_reg == OP_INSERT)
                    begin
                        status    <= (found_reg || have_free_reg) ? ST_OK : ST_FULL;
                        state_reg <= S_OUT;
                        out_valid <= 1'b1;
                    end
                    else if (found_reg)
                    begin
                        status    <= ST_OK;
                        state_reg <= S_VREAD;
                    end
                    else
                    begin
                        status    <= ST_NOTFOUND;
                        state_reg <= S_OUT;
                        out_valid <= 1'b1;
                    end
                end
                S_VREAD:
                begin
                    state_reg <= S_VWAIT;
                end
                S_VWAIT:
                begin
                    value_out <= v_rd;
                    out_valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_OUT))
        else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SCAN))
        else $error("accepted item did not start a probe");
    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (op_reg == OP_INSERT && !existed))
        else $error("full status on non-insert");
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("item taken during clear sweep");
`endif
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for swiss_hash_table_engine: directed and random find/insert/remove items,
// each checked against an in-bench model of the hash table. Depends on sht_pkg and the RTL.
`timescale 1ns / 100ps
module testbench;
    import sht_pkg::*;

    localparam int TOTAL    = BUCKETS * SLOTS;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic        existed;
        logic [31:0] value_out;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [63:0] hash;
    logic [31:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        existed;
    logic [31:0] value_out;

    // model copy of the table
    logic [7:0]  tbl_tag [TOTAL];
    logic [31:0] tbl_key [TOTAL];
    logic [31:0] tbl_val [TOTAL];

    result_t     pending_results[$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    bit          hold_off_req;

    // small pool of keys with fixed hashes so hits and collisions are frequent
    logic [63:0] pool_hash [64];
    logic [31:0] pool_key  [64];

    swiss_hash_table_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .hash(hash), .key(key), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .existed(existed), .value_out(value_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t table_apply(logic [1:0] r_op, logic [63:0] r_hash,
                                            logic [31:0] r_key, logic [31:0] r_val);
        result_t     r;
        logic [56:0] home;
        logic [7:0]  rtag;
        logic [5:0]  bkt;
        bit          found;
        bit          have_free;
        bit          all_empty;
        int          hit_idx;
        int          free_idx;
        int          idx;
        home = r_hash[56:0];
        rtag = {1'b0, r_hash[63:57]};
        if (rtag == TAG_EMPTY)
            rtag = TAG_ZFIX;
        found = 0;
        have_free = 0;
        hit_idx = 0;
        free_idx = 0;
        r = '0;
        for (int p = 0; p < BUCKETS && !found; p++)
        begin
            bkt = home[5:0] + 6'((p * (p + 1)) / 2);
            all_empty = 1;
            for (int s = 0; s < SLOTS; s++)
            begin
                idx = bkt * SLOTS + s;
                if (tbl_tag[idx] != TAG_EMPTY)
                    all_empty = 0;
                if (!found && tbl_tag[idx] == rtag && tbl_key[idx] == r_key)
                begin
                    found = 1;
                    hit_idx = idx;
                end
                if (!have_free && (tbl_tag[idx] == TAG_EMPTY || tbl_tag[idx] == TAG_TOMB))
                begin
                    have_free = 1;
                    free_idx = idx;
                end
            end
            if (all_empty)
                break;
        end
        if (r_op == OP_INSERT)
        begin
            if (found)
            begin
                tbl_val[hit_idx] = r_val;
                r.existed = 1'b1;
            end
            else if (have_free)
            begin
                tbl_tag[free_idx] = rtag;
                tbl_key[free_idx] = r_key;
                tbl_val[free_idx] = r_val;
            end
            else
                r.status = ST_FULL;
        end
        else if (found)
        begin
            r.existed = 1'b1;
            r.value_out = tbl_val[hit_idx];
            if (r_op == OP_REMOVE)
                tbl_tag[hit_idx] = TAG_TOMB;
        end
        else
            r.status = ST_NOTFOUND;
        return r;
    endfunction

    // drive one item, with burst/gap idling
    task automatic send_item(logic [1:0] i_op, logic [63:0] i_hash,
                             logic [31:0] i_key, logic [31:0] i_val);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        // step past the negedge where the previous item dropped valid
        @(negedge clk);
        in_valid <= 1'b1;
        op       <= i_op;
        hash     <= i_hash;
        key      <= i_key;
        value    <= i_val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(table_apply(i_op, i_hash, i_key, i_val));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [1:0] rand_op;
        return 2'($urandom_range(0, 3));
    endfunction

    task automatic pool_item(logic [1:0] i_op);
        int k;
        k = $urandom_range(0, 63);
        send_item(i_op, pool_hash[k], pool_key[k], $urandom);
    endtask

    task automatic test_directed;
        // empty table misses, tag of zero, field extremes, unused op
        send_item(OP_FIND, 64'h0, 32'h0, 32'h0);
        send_item(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_INSERT, 64'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_FIND, 64'h0, 32'h0, 32'h0);
        send_item(OP_INSERT, 64'h0, 32'h0, 32'h1234_5678);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        // same tag, key differs only in upper bits
        send_item(OP_FIND, 64'h0, 32'h8000_0000, 32'h0);
        send_item(OP_REMOVE, 64'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_FIND, 64'h0, 32'h0, 32'h0);
        // refill tombstone
        send_item(OP_INSERT, 64'h0, 32'h0, 32'hA5A5_A5A5);
        send_item(OP_REMOVE, 64'h0, 32'h0, 32'h0);
        // tag of 0x7F vs a zero tag mapped to 0xFF: same key, different top bits
        send_item(OP_INSERT, 64'hFE00_0000_0000_0003, 32'h77, 32'h1);
        send_item(OP_FIND, 64'h0000_0000_0000_0003, 32'h77, 32'h0);
        // overflow one bucket so probing moves on
        for (int i = 0; i < 18; i++)
            send_item(OP_INSERT, 64'h1000_0000_0000_0005, 32'(i + 100), 32'(i));
        send_item(OP_FIND, 64'h1000_0000_0000_0005, 32'd117, 32'h0);
        drain();
    endtask

    // fill the table to report full, then free some slots by removes
    task automatic test_full_table;
        for (int i = 0; i < TOTAL + 4; i++)
            send_item(OP_INSERT, {7'h11, 57'(i)}, 32'(32'h4000_0000 + i), $urandom);
        send_item(OP_FIND, {7'h11, 57'd5}, 32'h4000_0005, 32'h0);
        for (int i = 0; i < 40; i++)
            send_item(OP_REMOVE, {7'h11, 57'(i)}, 32'(32'h4000_0000 + i), $urandom);
        // free slots are now tombstones; inserts must reuse them
        for (int i = 0; i < 8; i++)
            send_item(OP_INSERT, {$urandom, $urandom}, $urandom, $urandom);
        drain();
    endtask

    task automatic test_random;
        for (int i = 0; i < 120; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                pool_item(rand_op());
            else
                send_item(rand_op(), {$urandom, $urandom}, $urandom, $urandom);
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure;
        hold_off_req = 1'b1;
        for (int i = 0; i < 20; i++)
            pool_item(rand_op());
        drain();
    endtask

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            case ($urandom_range(0, 3))
                0: out_ready <= 1'b0;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            idle_cycles = 0;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d existed=%0b value_out=%h",
                             status, existed, value_out);
            end
            else
            begin
                result_t exp_r;
                exp_r = pending_results.pop_front();
                if (exp_r.status !== status || exp_r.existed !== existed
                    || exp_r.value_out !== value_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b/%h got %0d/%0b/%h",
                                 exp_r.status, exp_r.existed, exp_r.value_out,
                                 status, existed, value_out);
                end
            end
        end
        else if (rst_n && in_valid && in_ready)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_FIND;
        hash = '0;
        key = '0;
        value = '0;
        mismatches = 0;
        idle_cycles = -2000;   // allow for the tag clear sweep
        burst_left = 0;
        hold_off_req = 1'b0;
        for (int i = 0; i < TOTAL; i++)
        begin
            tbl_tag[i] = TAG_EMPTY;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        for (int i = 0; i < 64; i++)
        begin
            pool_hash[i] = {$urandom, $urandom};
            pool_key[i]  = $urandom;
            if (i % 8 == 1)
                pool_hash[i] = pool_hash[i - 1];   // same hash, other key
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        test_full_table();
        drain();
        repeat (50) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ swiss_hash_table_engine.f @@
hw/rtl/sht_pkg.sv
hw/rtl/sht_ram.sv
hw/rtl/swiss_hash_table_engine.sv
tb/testbench.sv
